[design/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cursor engine
// Screen geometry, command and result codes, and the words that pass between
// the front, back and output queue.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // screen geometry
    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 4;

    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS + 1);   // one extra code for past-bottom
    localparam int SP_W  = $clog2(TAB_SPACES + 1);

    // field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int PX_W   = 8;
    localparam int PY_W   = 6;
    localparam int LN_W   = 5;
    localparam int CLR_W  = 4;
    localparam int KIND_W = 3;

    // signed widths for move arithmetic (target or delta plus cursor)
    localparam int MX_W = ((COL_W + 1 > PX_W) ? COL_W + 1 : PX_W) + 1;
    localparam int MY_W = ((ROW_W + 1 > PY_W) ? ROW_W + 1 : PY_W) + 1;

    // queue depths
    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;
    localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

    // input commands
    localparam logic [CMD_W-1:0] CMD_PRINT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE_ABS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE_REL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SCROLL   = 2'd3;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // classified operation
    typedef enum logic [3:0] {
        OP_GLYPH,
        OP_BS,
        OP_FF,
        OP_NL,
        OP_CR,
        OP_VT,
        OP_TAB,
        OP_MOVE_ABS,
        OP_MOVE_REL,
        OP_SCROLL
    } t_op;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_REPORT = 3'd0,
        KIND_DRAW   = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_COPY   = 3'd3,
        KIND_FILL   = 3'd4
    } t_kind;

    // back-end sequencer phase
    typedef enum logic [1:0] {
        PH_MAIN,
        PH_POST,
        PH_FILL
    } t_phase;

    // classified word from front to back
    typedef struct packed {
        t_op                      op;
        logic [CHAR_W-1:0]        code;
        logic signed [PX_W-1:0]   pos_x;
        logic signed [PY_W-1:0]   pos_y;
        logic [LN_W-1:0]          lines;   // already limited to ROWS
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // result word
    typedef struct packed {
        t_kind             kind;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic [CHAR_W-1:0] glyph;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
        logic [LN_W-1:0]   amount;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result res;
    } t_rpush;

endpackage

[design/text_console_cursor_engine_unit.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit: character-cell console cursor engine
// Top level: configuration registers, command front end, cursor sequencer
// and result queue.
// ----------------------------------------------------------------------------
// Commands enter through a two-word queue and results leave through a
// two-word queue; the cursor sequencer between them emits one result word
// per clock while a command waits and the result queue has room. A command
// that yields one result (plain character, control character, move, scroll
// by zero) is taken with that result. A scroll yields a copy and a fill, a
// printable on the past-bottom row or a wrap off the last row adds a clear,
// and a tab yields one result per space plus any clear, at most five
// results. The first result word is registered in the command queue and
// then in the result queue before it reaches the output ports. Colors are
// written through the valid/ready port, which is always ready; write them
// only while the engine is idle.
module text_console_cursor_engine_unit import tcce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command queue side
    input  logic                   push,
    output logic                   full,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [CHAR_W-1:0]      i_char_code,
    input  logic signed [PX_W-1:0] i_pos_x,
    input  logic signed [PY_W-1:0] i_pos_y,
    input  logic [LN_W-1:0]        i_scroll_lines,
    // result queue side
    output logic                   empty,
    input  logic                   pop,
    output logic [KIND_W-1:0]      o_kind,
    output logic [COL_W-1:0]       o_cell_col,
    output logic [ROW_W-1:0]       o_cell_row,
    output logic [CHAR_W-1:0]      o_glyph,
    output logic [CLR_W-1:0]       o_fg_out,
    output logic [CLR_W-1:0]       o_bg_out,
    output logic [LN_W-1:0]        o_row_amount,
    output logic [COL_W-1:0]       o_cursor_col,
    output logic [ROW_W-1:0]       o_cursor_row,
    output logic                   o_last,
    // configuration write port
    input  logic                   valid,
    output logic                   ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CLR_W-1:0]       i_cfg_data
);

    logic [CLR_W-1:0] r_fg, r_bg;
    t_qhead           w_head;
    logic             w_pop_item;
    t_rpush           w_rpush;
    logic             w_out_full;
    t_result          w_res;

    // color registers
    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (valid && ready) begin
            unique case (i_cfg_index)
                CFG_FG: r_fg <= i_cfg_data;
                CFG_BG: r_bg <= i_cfg_data;
            endcase
        end
    end

    // front end: decode and command queue
    tcce_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_scroll_lines (i_scroll_lines),
        .o_head         (w_head),
        .i_pop          (w_pop_item)
    );

    // back end: cursor sequencer
    tcce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop_item),
        .i_fg       (r_fg),
        .i_bg       (r_bg),
        .o_out      (w_rpush),
        .i_out_full (w_out_full)
    );

    // result queue
    tcce_out_queue u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (w_rpush),
        .o_full  (w_out_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_res)
    );

    assign o_kind       = w_res.kind;
    assign o_cell_col   = w_res.cell_col;
    assign o_cell_row   = w_res.cell_row;
    assign o_glyph      = w_res.glyph;
    assign o_fg_out     = w_res.fg;
    assign o_bg_out     = w_res.bg;
    assign o_row_amount = w_res.amount;
    assign o_cursor_col = w_res.cur_col;
    assign o_cursor_row = w_res.cur_row;
    assign o_last       = w_res.last;

endmodule

[design/tcce_front.sv]
// ----------------------------------------------------------------------------
// tcce_front: input side of the console engine
// Decodes each accepted command into an operation word and holds it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
module tcce_front import tcce_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [CHAR_W-1:0]      i_char_code,
    input  logic signed [PX_W-1:0] i_pos_x,
    input  logic signed [PY_W-1:0] i_pos_y,
    input  logic [LN_W-1:0]        i_scroll_lines,
    output t_qhead                 o_head,
    input  logic                   i_pop
);

    localparam int PTR_W = $clog2(IQ_DEPTH);
    localparam int CNT_W = $clog2(IQ_DEPTH + 1);

    t_item              r_mem [IQ_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    t_item              w_item;
    logic               w_wr_en, w_rd_en;

    // decode the command
    always_comb begin
        w_item       = '0;
        w_item.code  = i_char_code;
        w_item.pos_x = i_pos_x;
        w_item.pos_y = i_pos_y;
        if (32'(i_scroll_lines) > ROWS) begin
            w_item.lines = LN_W'(ROWS);
        end else begin
            w_item.lines = i_scroll_lines;
        end
        unique case (i_cmd)
            CMD_PRINT: begin
                unique case (i_char_code)
                    CH_BS:   w_item.op = OP_BS;
                    CH_FF:   w_item.op = OP_FF;
                    CH_NL:   w_item.op = OP_NL;
                    CH_CR:   w_item.op = OP_CR;
                    CH_VT:   w_item.op = OP_VT;
                    CH_TAB:  w_item.op = OP_TAB;
                    default: w_item.op = OP_GLYPH;
                endcase
            end
            CMD_MOVE_ABS: w_item.op = OP_MOVE_ABS;
            CMD_MOVE_REL: w_item.op = OP_MOVE_REL;
            CMD_SCROLL:   w_item.op = OP_SCROLL;
        endcase
    end

    assign o_full  = (r_cnt == CNT_W'(IQ_DEPTH));
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && (r_cnt != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (32'(r_wr) == IQ_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (32'(r_rd) == IQ_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

endmodule

[design/tcce_back.sv]
// ----------------------------------------------------------------------------
// tcce_back: cursor sequencer of the console engine
// Owns the cursor and turns each operation word into results, one per cycle
// while the result queue has room: clear before a draw past the bottom, draw,
// clear after a wrap off the bottom, tab spaces, and the copy/fill pair of a scroll.
// ----------------------------------------------------------------------------
module tcce_back import tcce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qhead           i_head,
    output logic             o_pop,
    input  logic [CLR_W-1:0] i_fg,
    input  logic [CLR_W-1:0] i_bg,
    output t_rpush           o_out,
    input  logic             i_out_full
);

    t_phase              r_phase, n_phase;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_line, n_line;
    logic [SP_W-1:0]     r_spaces, n_spaces;

    t_item               w_it;
    t_result             w_res;
    logic                w_go, w_done;
    logic                w_is_print, w_more, w_pre_clr, w_wrap, w_post;
    logic [ROW_W-1:0]    w_draw_line, w_lines;
    logic [CHAR_W-1:0]   w_glyph;
    logic signed [MX_W-1:0] w_mx;
    logic signed [MY_W-1:0] w_my;

    assign w_it = i_head.item;
    assign w_go = i_head.valid && !i_out_full;

    // decode helpers
    assign w_is_print  = (w_it.op == OP_GLYPH) || (w_it.op == OP_TAB);
    assign w_more      = (w_it.op == OP_TAB) && (32'(r_spaces) < TAB_SPACES - 1);
    assign w_pre_clr   = (32'(r_line) >= ROWS);
    assign w_wrap      = (32'(r_col) + 1 >= COLS);
    assign w_draw_line = w_wrap ? r_line + 1'b1 : r_line;
    assign w_post      = (32'(w_draw_line) >= ROWS);
    assign w_glyph     = (w_it.op == OP_TAB) ? CH_SPACE : w_it.code;
    assign w_lines     = ROW_W'(w_it.lines);

    // move targets, absolute or relative
    always_comb begin
        w_mx = MX_W'(w_it.pos_x);
        w_my = MY_W'(w_it.pos_y);
        if (w_it.op == OP_MOVE_REL) begin
            w_mx = w_mx + $signed(MX_W'(r_col));
            w_my = w_my + $signed(MY_W'(r_line));
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_MAIN: begin
                if (w_is_print && !w_pre_clr && w_post) begin
                    n_phase = PH_POST;
                end else if (w_it.op == OP_SCROLL && w_it.lines != '0) begin
                    n_phase = PH_FILL;
                end
            end
            PH_POST: n_phase = PH_MAIN;
            PH_FILL: n_phase = PH_MAIN;
            default: n_phase = PH_MAIN;
        endcase
    end

    // result word and cursor update
    always_comb begin
        w_res    = '0;
        n_col    = r_col;
        n_line   = r_line;
        n_spaces = r_spaces;
        w_done   = 1'b0;
        w_res.kind = KIND_REPORT;
        unique case (w_it.op)
            OP_GLYPH, OP_TAB: begin
                if (r_phase == PH_POST || w_pre_clr) begin
                    // clear to home
                    w_res.kind = KIND_CLEAR;
                    w_res.bg   = i_bg;
                    n_col      = '0;
                    n_line     = '0;
                    if (r_phase == PH_POST) begin
                        if (w_more) begin
                            n_spaces = r_spaces + 1'b1;
                        end else begin
                            w_done = 1'b1;
                        end
                    end
                end else begin
                    w_res.kind     = KIND_DRAW;
                    w_res.cell_col = r_col;
                    w_res.cell_row = r_line;
                    w_res.glyph    = w_glyph;
                    w_res.fg       = i_fg;
                    w_res.bg       = i_bg;
                    n_col          = w_wrap ? '0 : r_col + 1'b1;
                    n_line         = w_draw_line;
                    if (!w_post) begin
                        if (w_more) begin
                            n_spaces = r_spaces + 1'b1;
                        end else begin
                            w_done = 1'b1;
                        end
                    end
                end
            end
            OP_BS: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end
                w_done = 1'b1;
            end
            OP_FF: begin
                w_res.kind = KIND_CLEAR;
                w_res.bg   = i_bg;
                n_col      = '0;
                n_line     = '0;
                w_done     = 1'b1;
            end
            OP_NL, OP_VT: begin
                if (w_it.op == OP_NL) begin
                    n_col = '0;
                end
                if (32'(r_line) < ROWS) begin
                    n_line = r_line + 1'b1;
                end
                w_done = 1'b1;
            end
            OP_CR: begin
                n_col  = '0;
                w_done = 1'b1;
            end
            OP_MOVE_ABS, OP_MOVE_REL: begin
                if (w_mx < 0) begin
                    n_col = '0;
                end else if (w_mx > $signed(MX_W'(COLS - 1))) begin
                    n_col = COL_W'(COLS - 1);
                end else begin
                    n_col = COL_W'(w_mx);
                end
                if (w_my < 0) begin
                    n_line = '0;
                end else if (w_my > $signed(MY_W'(ROWS - 1))) begin
                    n_line = ROW_W'(ROWS - 1);
                end else begin
                    n_line = ROW_W'(w_my);
                end
                w_done = 1'b1;
            end
            OP_SCROLL: begin
                if (r_phase == PH_FILL) begin
                    w_res.kind     = KIND_FILL;
                    w_res.cell_row = ROW_W'(ROWS - 32'(w_it.lines));
                    w_res.bg       = i_bg;
                    w_done         = 1'b1;
                end else if (w_it.lines == '0) begin
                    w_done = 1'b1;
                end else begin
                    w_res.kind   = KIND_COPY;
                    w_res.amount = w_it.lines;
                    n_line       = (r_line > w_lines) ? r_line - w_lines : '0;
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
        w_res.cur_col = n_col;
        w_res.cur_row = n_line;
        w_res.last    = w_done;
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAIN;
            r_col    <= '0;
            r_line   <= '0;
            r_spaces <= '0;
        end else if (w_go) begin
            r_col  <= n_col;
            r_line <= n_line;
            if (w_done) begin
                r_phase  <= PH_MAIN;
                r_spaces <= '0;
            end else begin
                r_phase  <= n_phase;
                r_spaces <= n_spaces;
            end
        end
    end

    assign o_pop      = w_go && w_done;
    assign o_out.push = w_go;
    assign o_out.res  = w_res;

endmodule

[design/tcce_out_queue.sv]
// ----------------------------------------------------------------------------
// tcce_out_queue: result queue of the console engine
// Holds finished result words until the consumer pops them, so the back end
// keeps running while a result waits.
// ----------------------------------------------------------------------------
module tcce_out_queue import tcce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_rpush  i_in,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    t_result          r_mem [OQ_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr_en, w_rd_en;

    assign o_full  = (r_cnt == CNT_W'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr_en = i_in.push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    // result storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_in.res;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (32'(r_wr) == OQ_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (32'(r_rd) == OQ_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_res = r_mem[r_rd];

endmodule

[design/tcce_checker.sv]
// ----------------------------------------------------------------------------
// tcce_checker: port-level checks for the console engine
// Watches the result queue side and flags words the engine must never show.
// ----------------------------------------------------------------------------
module tcce_checker import tcce_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [KIND_W-1:0] o_kind,
    input logic [ROW_W-1:0]  o_cell_row,
    input logic [COL_W-1:0]  o_cursor_col,
    input logic [ROW_W-1:0]  o_cursor_row,
    input logic              o_last
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a waiting word holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kind) && $stable(o_cursor_row))
        else $error("waiting result changed before pop");

    // reported cursor stays on or just below the screen
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_cursor_col) < COLS) && (32'(o_cursor_row) <= ROWS))
        else $error("cursor outside screen");

    // a clear always sends the cursor home
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_kind == KIND_CLEAR |-> o_cursor_col == '0 && o_cursor_row == '0)
        else $error("clear without cursor home");

    // a copy is always followed by its fill; a drawn cell is on screen
    a_copy_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind != KIND_COPY || !o_last)
                && (o_kind != KIND_DRAW || 32'(o_cell_row) < ROWS))
        else $error("copy marked last or glyph drawn off screen");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_checker (.*);
